FILE: rtl/core/ptdt_pkg.sv
`timescale 1ns / 1ps

package ptdt_pkg;

    localparam int VERDICT_BITS = 2;

    typedef logic [VERDICT_BITS-1:0] t_verdict;

    localparam t_verdict VERDICT_SKIPPED      = 2'd0;
    localparam t_verdict VERDICT_PRIME_STORED = 2'd1;
    localparam t_verdict VERDICT_COMPOSITE    = 2'd2;
    localparam t_verdict VERDICT_PRIME_FULL   = 2'd3;

endpackage

FILE: rtl/core/ptdt_ram.sv
`timescale 1ns / 1ps

module ptdt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/ptdt_div.sv
`timescale 1ns / 1ps

module ptdt_div #(
    parameter int WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic             o_busy,
    output logic [WIDTH-1:0] o_remainder
);

    localparam int CW = $clog2(WIDTH + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_dvd;
    logic [WIDTH-1:0] r_dsr;
    logic [WIDTH:0]   w_trial;
    logic [WIDTH:0]   w_diff;
    logic             w_ge;

    // One restoring step per cycle: shift in the next dividend bit and subtract if it fits.
    always_comb begin
        w_trial = {r_rem, r_dvd[WIDTH-1]};
        w_diff  = w_trial - {1'b0, r_dsr};
        w_ge    = (w_trial >= {1'b0, r_dsr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(WIDTH);
        end else if (r_busy && (r_cnt == '0)) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy && (r_cnt != '0)) begin
            r_rem <= w_ge ? w_diff[WIDTH-1:0] : w_trial[WIDTH-1:0];
            r_dvd <= {r_dvd[WIDTH-2:0], 1'b0};
        end
    end

    assign o_done      = r_busy && (r_cnt == '0);
    assign o_busy      = r_busy;
    assign o_remainder = r_rem;

endmodule

FILE: rtl/core/prime_trial_division_tester_core.sv
`timescale 1ns / 1ps
// One shared bit-serial divider does each trial, dividing the candidate by the stored primes
// in turn; a skipped candidate gets its result without any division.
// Throughput: one transaction at a time; a new one is accepted the cycle after the previous
// result enters the output register, which waits while an earlier result is unread.
// Reset: synchronous, active low; the table holds 2 and 3 and the prime count returns to 2.
module prime_trial_division_tester_core #(
    parameter int TABLE_DEPTH = 64,
    parameter int VALUE_BITS  = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // Fields from bit 0: candidate.
    input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // Fields from bit 0: verdict, divisor.
    output logic [((ptdt_pkg::VERDICT_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] o_m_axis_tdata
);

    import ptdt_pkg::*;

    localparam int OUT_W  = ((VERDICT_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int DIGITS = (VALUE_BITS + 1) / 2;
    localparam int SUM_W  = $clog2(3 * DIGITS + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOD6  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]              r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_out_valid, n_out_valid;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic [VALUE_BITS-1:0]   r_cand, n_cand;
    logic [VALUE_BITS-1:0]   r_p, n_p;
    logic [2*VALUE_BITS-1:0] r_sq, n_sq;
    t_verdict                r_res_verdict, n_res_verdict;
    logic [VALUE_BITS-1:0]   r_res_divisor, n_res_divisor;
    t_verdict                r_out_verdict, n_out_verdict;
    logic [VALUE_BITS-1:0]   r_out_divisor, n_out_divisor;

    logic                    w_accept;
    logic                    w_div_start;
    logic [VALUE_BITS-1:0]   w_div_dvd;
    logic [VALUE_BITS-1:0]   w_div_dsr;
    logic                    w_div_done;
    logic                    w_div_busy;
    logic [VALUE_BITS-1:0]   w_div_rem;
    logic                    w_ram_we;
    logic [VALUE_BITS-1:0]   w_ram_rdata;
    logic [VALUE_BITS-1:0]   w_p;
    t_verdict                w_prime_verdict;
    logic [2*DIGITS-1:0]     w_cand_ext;
    logic [SUM_W-1:0]        w_dsum;
    logic [5:0]              w_dsum_ext;
    logic [3:0]              w_fold;
    logic                    w_mult3;

    ptdt_div #(
        .WIDTH(VALUE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dsr),
        .o_done     (w_div_done),
        .o_busy     (w_div_busy),
        .o_remainder(w_div_rem)
    );

    // Entries 0 and 1 are the fixed primes 2 and 3 and are never written.
    ptdt_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(r_count[ADDR_W-1:0]),
        .i_wdata(r_cand),
        .i_raddr(r_idx[ADDR_W-1:0]),
        .o_rdata(w_ram_rdata)
    );

    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'({r_out_divisor, r_out_verdict});

    // A candidate is on the 6k +/- 1 wheel when it is odd and not a multiple of 3.
    // Base-4 digit sums keep the residue modulo 3, so two folds reduce it to at most 9.
    always_comb begin
        w_cand_ext = (2*DIGITS)'(r_cand);
        w_dsum     = '0;
        for (int i = 0; i < DIGITS; i++) begin
            w_dsum = w_dsum + SUM_W'(w_cand_ext[2*i +: 2]);
        end
        w_dsum_ext = 6'(w_dsum);
        w_fold     = 4'(w_dsum_ext[1:0]) + 4'(w_dsum_ext[3:2]) + 4'(w_dsum_ext[5:4]);
        w_mult3    = (w_fold == 4'd0) || (w_fold == 4'd3) || (w_fold == 4'd6) ||
                     (w_fold == 4'd9);
    end

    always_comb begin
        if (r_idx == CNT_W'(0)) begin
            w_p = VALUE_BITS'(2);
        end else if (r_idx == CNT_W'(1)) begin
            w_p = VALUE_BITS'(3);
        end else begin
            w_p = w_ram_rdata;
        end
        w_prime_verdict = (r_count < DEPTH_C) ? VERDICT_PRIME_STORED : VERDICT_PRIME_FULL;
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_out_valid   = r_out_valid && !i_m_axis_tready;
        n_idx         = r_idx;
        n_cand        = r_cand;
        n_p           = r_p;
        n_sq          = r_sq;
        n_res_verdict = r_res_verdict;
        n_res_divisor = r_res_divisor;
        n_out_verdict = r_out_verdict;
        n_out_divisor = r_out_divisor;
        w_div_start   = 1'b0;
        w_div_dvd     = r_cand;
        w_div_dsr     = r_p;
        w_ram_we      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cand  = i_s_axis_tdata[VALUE_BITS-1:0];
                    n_state = S_MOD6;
                end
            end
            S_MOD6: begin
                if ((r_cand < VALUE_BITS'(5)) || !r_cand[0] || w_mult3) begin
                    n_res_verdict = VERDICT_SKIPPED;
                    n_res_divisor = '0;
                    n_state       = S_OUT;
                end else begin
                    n_idx   = '0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_idx == r_count) begin
                    n_res_verdict = w_prime_verdict;
                    n_res_divisor = '0;
                    n_state       = S_OUT;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_p     = w_p;
                n_sq    = (2*VALUE_BITS)'(w_p) * (2*VALUE_BITS)'(w_p);
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_p == '0) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_READ;
                end else if (r_sq > (2*VALUE_BITS)'(r_cand)) begin
                    n_res_verdict = w_prime_verdict;
                    n_res_divisor = '0;
                    n_state       = S_OUT;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    if (w_div_rem == '0) begin
                        n_res_verdict = VERDICT_COMPOSITE;
                        n_res_divisor = r_p;
                        n_state       = S_OUT;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid   = 1'b1;
                    n_out_verdict = r_res_verdict;
                    n_out_divisor = r_res_divisor;
                    if (r_res_verdict == VERDICT_PRIME_STORED) begin
                        w_ram_we = 1'b1;
                        n_count  = r_count + 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= CNT_W'(2);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_cand        <= n_cand;
        r_p           <= n_p;
        r_sq          <= n_sq;
        r_res_verdict <= n_res_verdict;
        r_res_divisor <= n_res_divisor;
        r_out_verdict <= n_out_verdict;
        r_out_divisor <= n_out_divisor;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) && (r_count <= DEPTH_C))
        else $error("prime count out of range");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_count < DEPTH_C))
        else $error("table write while full");

    a_divisor_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_verdict == VERDICT_COMPOSITE) == (r_out_divisor != '0)))
        else $error("divisor does not match verdict");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_axis_tready)
        else $error("not busy after accepted transaction");

    a_div_idle_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !w_div_busy)
        else $error("divider busy while ready for a transaction");

endmodule

FILE: bench/tb_prime_trial_division_tester_core.sv
`timescale 1ns / 1ps

module tb_prime_trial_division_tester_core;
    import ptdt_pkg::*;

    localparam int TABLE_DEPTH  = 64;
    localparam int VALUE_BITS   = 16;
    localparam int IN_BITS      = ((VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_BITS     = ((VERDICT_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 1500;
    localparam int MAX_WHEEL_K  = ((1 << VALUE_BITS) - 2) / 6;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef struct packed {
        t_verdict verdict;
        t_value   divisor;
    } t_outcome;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_BITS-1:0]  s_tdata  = '0;  // Fields from bit 0: candidate.
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_BITS-1:0] m_tdata;        // Fields from bit 0: verdict, divisor.

    t_value      candidate_queue[$];
    t_outcome    expected_outcomes[$];
    t_value      prime_list[TABLE_DEPTH];
    int          prime_total;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_arm       = 1'b0;
    int          hold_left      = 0;
    int          items_sent     = 0;
    int          failures       = 0;
    int          verdicts_seen[4] = '{0, 0, 0, 0};

    t_value directed_candidates[24] = '{
        0, 1, 2, 3, 4, 6, 8, 9, 10, 12, 25, 5, 5, 7, 35, 49, 635, 625,
        65535, 65534, 32768, 11, 13, 55
    };

    prime_trial_division_tester_core #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata)
    );

    always #2 clk = ~clk;

    function automatic t_outcome classify_candidate(t_value cand);
        t_outcome                res;
        logic [2*VALUE_BITS-1:0] factor;
        res.verdict = VERDICT_SKIPPED;
        res.divisor = '0;
        if (cand < 5 || (cand % 6 != 1 && cand % 6 != 5)) begin
            return res;
        end
        for (int idx = 0; idx < prime_total; idx++) begin
            factor = prime_list[idx];
            if (factor == 0) continue;
            if (factor * factor > cand) break;
            if (cand % factor == 0) begin
                res.verdict = VERDICT_COMPOSITE;
                res.divisor = prime_list[idx];
                return res;
            end
        end
        if (prime_total < TABLE_DEPTH) begin
            prime_list[prime_total] = cand;
            prime_total++;
            res.verdict = VERDICT_PRIME_STORED;
        end else begin
            res.verdict = VERDICT_PRIME_FULL;
        end
        return res;
    endfunction

    // Mostly numbers on the 6k +/- 1 wheel, half of them small, the rest arbitrary noise.
    function automatic t_value random_candidate();
        int unsigned k;
        if ($urandom_range(99) < 30) begin
            return t_value'($urandom_range(0, (1 << VALUE_BITS) - 1));
        end
        k = $urandom_range(1, ($urandom_range(1) != 0) ? 1000 : MAX_WHEEL_K);
        return t_value'(($urandom_range(1) != 0) ? 6 * k + 1 : 6 * k - 1);
    endfunction

    task automatic queue_random_candidates(int count);
        repeat (count) candidate_queue.push_back(random_candidate());
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (candidate_queue.size() != 0 || s_tvalid || expected_outcomes.size() != 0);
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_outcomes.push_back(classify_candidate(s_tdata[VALUE_BITS-1:0]));
                items_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (candidate_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tdata  <= IN_BITS'(candidate_queue.pop_front());
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_arm) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || hold_arm || hold_left != 0) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin : result_check
        t_outcome want;
        t_outcome got;
        if (rst_n && m_tvalid && m_tready) begin
            got.verdict = m_tdata[VERDICT_BITS-1:0];
            got.divisor = m_tdata[VERDICT_BITS +: VALUE_BITS];
            if (expected_outcomes.size() == 0) begin
                $error("unexpected transaction: verdict %0d divisor %0d",
                       got.verdict, got.divisor);
                failures++;
            end else begin
                want = expected_outcomes.pop_front();
                verdicts_seen[got.verdict]++;
                if (got.verdict !== want.verdict) begin
                    $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
                    failures++;
                end
                if (got.divisor !== want.divisor) begin
                    $error("divisor: expected %0d, got %0d", want.divisor, got.divisor);
                    failures++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("tb_prime_trial_division_tester_core: FAIL");
        $finish;
    end

    initial begin
        prime_list  = '{default: '0};
        prime_list[0] = 2;
        prime_list[1] = 3;
        prime_total = 2;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_candidates[i]) candidate_queue.push_back(directed_candidates[i]);
        wait_idle();

        // Ascending walk along the wheel adds primes to the table, with a few numbers left out.
        send_idle_pct = 78;
        for (int k = 3; k < 40; k++) begin
            if ($urandom_range(9) != 0) candidate_queue.push_back(t_value'(6 * k - 1));
            if ($urandom_range(9) != 0) candidate_queue.push_back(t_value'(6 * k + 1));
        end
        wait_idle();

        send_idle_pct  = 0;
        recv_stall_pct = 78;
        queue_random_candidates(130);
        wait_idle();

        send_idle_pct  = 35;
        recv_stall_pct = 35;
        queue_random_candidates(130);
        wait_idle();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random_candidates(130);
        wait_idle();

        // The output is held off while short transactions keep arriving.
        hold_arm <= 1'b1;
        @(negedge clk);
        hold_arm <= 1'b0;
        repeat (16) candidate_queue.push_back(t_value'($urandom_range(0, 2000)));
        wait_idle();

        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Sent %0d candidates under four idling mixes and one long output hold-off.",
                 items_sent);
        $display("Verdicts: %0d skipped, %0d stored, %0d composite, %0d prime with table full.",
                 verdicts_seen[VERDICT_SKIPPED], verdicts_seen[VERDICT_PRIME_STORED],
                 verdicts_seen[VERDICT_COMPOSITE], verdicts_seen[VERDICT_PRIME_FULL]);
        if (failures == 0 && expected_outcomes.size() == 0) begin
            $display("tb_prime_trial_division_tester_core: PASS");
        end else begin
            $display("tb_prime_trial_division_tester_core: FAIL");
        end
        $finish;
    end

endmodule
